// ===== hw/rtl/hlfc_pkg.sv =====
// Shared types and constants for the host link frame codec.
package hlfc_pkg;

  // Default frame limit in bytes
  localparam int MAX_FRAME_DEF = 400;

  // Line framing bytes
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Link status trailer codes
  localparam logic [7:0] TR_OK      = 8'h01;
  localparam logic [7:0] TR_TIMEOUT = 8'hFE;
  localparam logic [7:0] TR_LINKSUM = 8'hFD;
  localparam logic [7:0] TR_LINKERR = 8'hFF;

  // Mask applied to the sign-extended order code (octal 0707)
  localparam logic [8:0] ACK_MASK = 9'o707;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SEND  = 2'd1,
    OP_END   = 2'd2,
    OP_REPLY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LINE   = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_INPUT_LONG  = 4'd1,
    ST_TIMEOUT     = 4'd2,
    ST_LINK_SUM    = 4'd3,
    ST_LINK_ERR    = 4'd4,
    ST_UNKNOWN     = 4'd5,
    ST_NO_ETX      = 4'd6,
    ST_SUM_MISS    = 4'd7,
    ST_REPLY_LONG  = 4'd8
  } status_t;

  // Receive parser phase
  typedef enum logic [2:0] {
    PH_FC   = 3'd0,
    PH_OC   = 3'd1,
    PH_SEEK = 3'd2,
    PH_BODY = 3'd3,
    PH_SUM  = 3'd4,
    PH_DONE = 3'd5,
    PH_OVER = 3'd6
  } phase_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    status_t    status;
    logic [8:0] ack_code;
    logic [8:0] reply_length;
  } res_t;

  localparam res_t RES_ZERO = '{KIND_LINE, 8'd0, ST_OK, 9'd0, 9'd0};

endpackage

// ===== hw/rtl/host_link_frame_codec_top.sv =====
// Host link frame codec: STX/ETX framing with XOR checksum, send and reply paths.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one word per op: start frame,
//    payload byte, end frame, or one received reply byte (reply_last marks the
//    link status trailer).
//  - Output channel (out_valid / out_stall) carries result words: line bytes to
//    send, recovered reply payload bytes, and status reports. last_of_run marks
//    the final result word of one input word.
//  - The first result of a word passes through the input register, then the
//    result bundle register, before it is presented on the output channel.
//  - Draining: a word that yields n results (start gives 3, end gives 2, or 1
//    once aborted) holds the result bundle register until all n are taken, since
//    the output port drains one word a cycle while out_stall is low. The next
//    input word may wait in the input register and is processed as the last result leaves.
//  - Reset (rst, synchronous) clears the send checksum and count, the abort
//    flag and the whole reply parser, and empties both pipeline registers.
//  - When the receiver stalls, the current result word holds; while the input
//    register is occupied and the bundle cannot free up, in_stall is raised.
module host_link_frame_codec_top #(
  parameter int MAX_FRAME = hlfc_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] function_code,
  input  logic [7:0] order_code,
  input  logic [7:0] data_byte,
  input  logic       reply_last,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic [3:0] status,
  output logic [8:0] ack_code,
  output logic [8:0] reply_length
);

  localparam int CW = $clog2(MAX_FRAME + 2);
  localparam logic [CW-1:0] SEND_LIM = CW'(MAX_FRAME - 8);
  localparam logic [CW-1:0] RX_MAX   = CW'(MAX_FRAME);

  // Input register
  logic       in_vld;
  logic [1:0] in_op;
  logic [7:0] in_fc;
  logic [7:0] in_oc;
  logic [7:0] in_db;
  logic       in_last;

  // Send state
  logic [7:0]    send_sum, send_sum_next;
  logic [CW-1:0] send_count, send_count_next;
  logic          send_aborted, send_aborted_next;

  // Receive state
  hlfc_pkg::phase_t reply_phase, reply_phase_next;
  logic [7:0]    reply_sum, reply_sum_next;
  logic [7:0]    held_function_code, held_function_code_next;
  logic [7:0]    held_order_code, held_order_code_next;
  logic [CW-1:0] reply_count, reply_count_next;
  logic          sum_mismatch, sum_mismatch_next;

  // Result bundle register
  hlfc_pkg::res_t bun [3];
  hlfc_pkg::res_t res_next [3];
  logic       bun_vld;
  logic [1:0] bun_idx;
  logic [1:0] bun_last;
  logic [1:0] n_res;

  logic bundle_free;
  logic advance;
  logic [CW-1:0] rc_inc;
  logic [CW+8:0] rc_ext;
  logic [7:0]    sum_tx;

  // Handshake control
  assign bundle_free = !bun_vld || ((bun_idx == bun_last) && !out_stall);
  assign advance     = in_vld && bundle_free;
  assign in_stall    = in_vld && !bundle_free;

  // Saturating reply byte counter
  assign rc_inc = (reply_count <= RX_MAX) ? reply_count + 1'b1 : reply_count;
  assign rc_ext = {9'd0, rc_inc};
  assign sum_tx = send_sum ^ in_db;

  // Per-word processing
  always_comb begin
    send_sum_next           = send_sum;
    send_count_next         = send_count;
    send_aborted_next       = send_aborted;
    reply_phase_next        = reply_phase;
    reply_sum_next          = reply_sum;
    held_function_code_next = held_function_code;
    held_order_code_next    = held_order_code;
    reply_count_next        = reply_count;
    sum_mismatch_next       = sum_mismatch;
    n_res                   = 2'd0;
    for (int i = 0; i < 3; i++) res_next[i] = hlfc_pkg::RES_ZERO;

    case (in_op)
      hlfc_pkg::OP_START: begin
        send_aborted_next    = 1'b0;
        send_count_next      = '0;
        res_next[0].out_byte = in_fc;
        res_next[1].out_byte = in_oc;
        res_next[2].out_byte = hlfc_pkg::STX_BYTE;
        send_sum_next        = in_fc ^ in_oc ^ hlfc_pkg::STX_BYTE;
        n_res                = 2'd3;
      end
      hlfc_pkg::OP_SEND: begin
        if (!send_aborted) begin
          send_count_next = send_count + 1'b1;
          n_res           = 2'd1;
          if (send_count >= SEND_LIM) begin
            send_aborted_next  = 1'b1;
            res_next[0].kind   = hlfc_pkg::KIND_STATUS;
            res_next[0].status = hlfc_pkg::ST_INPUT_LONG;
          end else begin
            res_next[0].out_byte = in_db;
            send_sum_next        = sum_tx;
          end
        end
      end
      hlfc_pkg::OP_END: begin
        if (send_aborted) begin
          res_next[0].kind   = hlfc_pkg::KIND_STATUS;
          res_next[0].status = hlfc_pkg::ST_INPUT_LONG;
          n_res              = 2'd1;
        end else begin
          send_sum_next        = send_sum ^ hlfc_pkg::ETX_BYTE;
          res_next[0].out_byte = hlfc_pkg::ETX_BYTE;
          res_next[1].out_byte = send_sum ^ hlfc_pkg::ETX_BYTE;
          n_res                = 2'd2;
        end
      end
      default: begin
        // received reply byte
        reply_count_next = rc_inc;
        if (in_last) begin
          res_next[0].kind         = hlfc_pkg::KIND_STATUS;
          res_next[0].reply_length = rc_ext[8:0];
          if (rc_inc > RX_MAX) begin
            res_next[0].status = hlfc_pkg::ST_REPLY_LONG;
          end else if (in_db == hlfc_pkg::TR_OK) begin
            if (reply_phase < hlfc_pkg::PH_SUM) begin
              res_next[0].status = hlfc_pkg::ST_NO_ETX;
            end else if (sum_mismatch) begin
              res_next[0].status = hlfc_pkg::ST_SUM_MISS;
            end else begin
              res_next[0].ack_code = {held_order_code[7], held_order_code} &
                                     hlfc_pkg::ACK_MASK;
            end
          end else if (in_db == hlfc_pkg::TR_TIMEOUT) begin
            res_next[0].status = hlfc_pkg::ST_TIMEOUT;
          end else if (in_db == hlfc_pkg::TR_LINKSUM) begin
            res_next[0].status = hlfc_pkg::ST_LINK_SUM;
          end else if (in_db == hlfc_pkg::TR_LINKERR) begin
            res_next[0].status = hlfc_pkg::ST_LINK_ERR;
          end else begin
            res_next[0].status = hlfc_pkg::ST_UNKNOWN;
          end
          n_res = 2'd1;
          // trailer ends the reply
          reply_phase_next        = hlfc_pkg::PH_FC;
          reply_sum_next          = 8'd0;
          held_function_code_next = 8'd0;
          held_order_code_next    = 8'd0;
          reply_count_next        = '0;
          sum_mismatch_next       = 1'b0;
        end else if (rc_inc > RX_MAX) begin
          reply_phase_next = hlfc_pkg::PH_OVER;
        end else begin
          case (reply_phase)
            hlfc_pkg::PH_FC: begin
              held_function_code_next = in_db;
              reply_sum_next          = reply_sum ^ in_db;
              reply_phase_next        = hlfc_pkg::PH_OC;
            end
            hlfc_pkg::PH_OC: begin
              held_order_code_next = in_db;
              reply_sum_next       = reply_sum ^ in_db;
              reply_phase_next     = hlfc_pkg::PH_SEEK;
            end
            hlfc_pkg::PH_SEEK: begin
              reply_sum_next = reply_sum ^ in_db;
              if (in_db == hlfc_pkg::STX_BYTE) begin
                res_next[0].kind     = hlfc_pkg::KIND_REPLY;
                res_next[0].out_byte = held_function_code;
                n_res                = 2'd1;
                reply_phase_next     = hlfc_pkg::PH_BODY;
              end
            end
            hlfc_pkg::PH_BODY: begin
              reply_sum_next       = reply_sum ^ in_db;
              res_next[0].kind     = hlfc_pkg::KIND_REPLY;
              res_next[0].out_byte = in_db;
              n_res                = 2'd1;
              if (in_db == hlfc_pkg::ETX_BYTE) reply_phase_next = hlfc_pkg::PH_SUM;
            end
            hlfc_pkg::PH_SUM: begin
              sum_mismatch_next = (reply_sum != in_db);
              reply_phase_next  = hlfc_pkg::PH_DONE;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_op   <= op;
      in_fc   <= function_code;
      in_oc   <= order_code;
      in_db   <= data_byte;
      in_last <= reply_last;
    end
  end

  // Codec state
  always_ff @(posedge clk) begin
    if (rst) begin
      send_sum           <= 8'd0;
      send_count         <= '0;
      send_aborted       <= 1'b0;
      reply_phase        <= hlfc_pkg::PH_FC;
      reply_sum          <= 8'd0;
      held_function_code <= 8'd0;
      held_order_code    <= 8'd0;
      reply_count        <= '0;
      sum_mismatch       <= 1'b0;
    end else if (advance) begin
      send_sum           <= send_sum_next;
      send_count         <= send_count_next;
      send_aborted       <= send_aborted_next;
      reply_phase        <= reply_phase_next;
      reply_sum          <= reply_sum_next;
      held_function_code <= held_function_code_next;
      held_order_code    <= held_order_code_next;
      reply_count        <= reply_count_next;
      sum_mismatch       <= sum_mismatch_next;
    end
  end

  // Result bundle: load on advance when there are results, drain one word per cycle unless stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      bun_vld <= 1'b0;
      bun_idx <= 2'd0;
    end else if (advance && (n_res != 2'd0)) begin
      bun_vld <= 1'b1;
      bun_idx <= 2'd0;
    end else if (bun_vld && !out_stall) begin
      if (bun_idx == bun_last) begin
        bun_vld <= 1'b0;
      end else begin
        bun_idx <= bun_idx + 1'b1;
      end
    end
    if (advance && (n_res != 2'd0)) begin
      bun_last <= n_res - 1'b1;
      for (int i = 0; i < 3; i++) bun[i] <= res_next[i];
    end
  end

  // Output word
  assign out_valid    = bun_vld;
  assign kind         = bun[bun_idx].kind;
  assign out_byte     = bun[bun_idx].out_byte;
  assign status       = bun[bun_idx].status;
  assign ack_code     = bun[bun_idx].ack_code;
  assign reply_length = bun[bun_idx].reply_length;
  assign last_of_run  = (bun_idx == bun_last);

endmodule
